// ----- design/sevseg_pkg.sv -----
// Shared widths, types and the segment table of the seven-segment frame encoder.
package sevseg_pkg;

    localparam int VALUE_W            = 27;
    localparam int PPOS_W             = 4;
    localparam int FRAME_W            = 16;
    localparam int IDX_W              = 3;
    localparam int DIGIT_W            = 4;
    localparam int DEFAULT_NUM_DIGITS = 8;

    // The top level packs these fields into the stream data words.
    localparam int S_TDATA_W = ((VALUE_W + PPOS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FRAME_W + IDX_W + 7) / 8) * 8;

    // Reciprocal of ten: floor(x * RECIP10 / 2^RECIP10_SHIFT) == x / 10 for any 32-bit x.
    localparam int          RECIP10_W     = 32;
    localparam int          RECIP10_SHIFT = 35;
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;

    localparam logic [7:0] POINT_BIT = 8'h01;

    // State held by one cell and handed on to its neighbor.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] rest;
        logic [PPOS_W-1:0]  ppos;
    } cell_t;

    // Active-high segment pattern of one decimal digit, bit 0 is the decimal point.
    function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'd252;
            4'd1:    pat = 8'd96;
            4'd2:    pat = 8'd218;
            4'd3:    pat = 8'd242;
            4'd4:    pat = 8'd102;
            4'd5:    pat = 8'd182;
            4'd6:    pat = 8'd62;
            4'd7:    pat = 8'd224;
            4'd8:    pat = 8'd254;
            4'd9:    pat = 8'd230;
            default: pat = 8'd0;
        endcase
        return pat;
    endfunction

endpackage

// ----- design/sevseg_cell.sv -----
// One digit cell: splits off one decimal digit, builds its frame, hands the quotient on.
module sevseg_cell
    import sevseg_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  cell_t              cell_in,
    output cell_t              cell_out,
    output logic               valid,
    output logic [FRAME_W-1:0] frame
);

    localparam int PROD_W = VALUE_W + RECIP10_W;
    localparam int QUOT_W = PROD_W - RECIP10_SHIFT;

    logic                     valid_reg;
    logic [VALUE_W-1:0]       rest_reg;
    logic [PPOS_W-1:0]        ppos_reg;
    logic [PROD_W-1:0]        prod;
    logic [VALUE_W-1:0]       quot;
    logic [VALUE_W-1:0]       remainder;
    logic [DIGIT_W-1:0]       digit;
    logic [7:0]               pattern;
    logic [7:0]               select;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rest_reg <= cell_in.rest;
            ppos_reg <= cell_in.ppos;
        end
    end

    always_comb begin
        prod      = PROD_W'(rest_reg) * PROD_W'(RECIP10);
        quot      = VALUE_W'(prod[PROD_W-1 -: QUOT_W]);
        remainder = rest_reg - ((quot << 3) + (quot << 1));
        digit     = remainder[DIGIT_W-1:0];
        pattern   = seg_pattern(digit);
        if (ppos_reg == PPOS_W'(INDEX)) begin
            pattern = pattern | POINT_BIT;
        end
        select    = 8'h80 >> INDEX;
        frame     = {select, ~pattern};
    end

    assign valid          = valid_reg;
    assign cell_out.valid = valid_reg;
    assign cell_out.rest  = quot;
    assign cell_out.ppos  = ppos_reg;

endmodule

// ----- design/seven_segment_frame_encoder.sv -----
// Top level of the seven-segment frame encoder: digit cell chain and output register.
//
//   Channel | Ports                                  | Payload
//   --------+----------------------------------------+------------------------------------
//   in      | s_tvalid, s_tready, s_tdata            | value [26:0], point_position [30:27]
//   out     | m_tvalid, m_tready, m_tdata, m_tlast   | frame [15:0], digit_index [18:16]
//
// Each request carries a number and a decimal point position. It enters a chain of
// NUM_DIGITS cells; cell i splits off decimal digit i with a multiply by the reciprocal
// of ten and hands the quotient to cell i+1 as the chain moves. Only one cell is busy at a
// time, and that cell's frame goes to the output register, so a request gives NUM_DIGITS
// frames, one per cycle unless m_tready stalls, least significant digit first, with
// m_tlast on the final one. A new request is taken while the last cell is busy, so it
// enters the chain before the previous request's final frame has gone out.
// Reset (aresetn low at a clock edge) empties the chain and the output register.
// A stall on m_tready freezes the whole chain and s_tready drops until it moves again.
module seven_segment_frame_encoder
    import sevseg_pkg::*;
#(
    parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // value [26:0], point_position [30:27], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // frame [15:0], digit_index [18:16], zero pad
    output logic                 m_tlast
);

    cell_t              link [NUM_DIGITS+1];
    logic               cell_valid [NUM_DIGITS];
    logic [FRAME_W-1:0] cell_frame [NUM_DIGITS];

    logic               advance;
    logic               busy;
    logic               any_valid;
    logic [FRAME_W-1:0] sel_frame;
    logic [IDX_W-1:0]   sel_idx;

    logic               m_tvalid_reg;
    logic [FRAME_W-1:0] m_frame_reg;
    logic [IDX_W-1:0]   m_idx_reg;
    logic               m_last_reg;

    // The chain moves whenever the output register is empty or being emptied.
    assign advance = !m_tvalid_reg || m_tready;

    // A request may enter only when no cell but the last still holds digits to do.
    always_comb begin
        busy = 1'b0;
        for (int i = 0; i < NUM_DIGITS - 1; i++) begin
            busy = busy | cell_valid[i];
        end
    end

    assign s_tready = advance && !busy;

    assign link[0].valid = s_tvalid && s_tready;
    assign link[0].rest  = s_tdata[VALUE_W-1:0];
    assign link[0].ppos  = s_tdata[VALUE_W +: PPOS_W];

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        sevseg_cell #(
            .INDEX (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .cell_in  (link[g]),
            .cell_out (link[g+1]),
            .valid    (cell_valid[g]),
            .frame    (cell_frame[g])
        );
    end

    // At most one cell is valid, so its frame and index are picked by an OR.
    always_comb begin
        any_valid = 1'b0;
        sel_frame = '0;
        sel_idx   = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            any_valid = any_valid | cell_valid[i];
            if (cell_valid[i]) begin
                sel_frame = sel_frame | cell_frame[i];
                sel_idx   = sel_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= any_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_frame_reg <= sel_frame;
            m_idx_reg   <= sel_idx;
            m_last_reg  <= cell_valid[NUM_DIGITS-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_idx_reg, m_frame_reg});
    assign m_tlast  = m_last_reg;

endmodule
